// ===== hdl/lvt_pkg.sv =====
package lvt_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int WORD_W      = 32;

    localparam logic [WORD_W-1:0] MISS_PATTERN = 32'hBF80_0000;
    localparam logic [WORD_W-1:0] EMPTY_LABEL  = '0;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // One request walking down the row of entries.
    typedef struct packed {
        logic              valid;
        logic              mode;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] value;
        logic              done;
        logic              fail;
        logic [WORD_W-1:0] data;
    } t_token;

endpackage

// ===== hdl/lvt_cell.sv =====
module lvt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lvt_pkg::t_token i_tok,
    output lvt_pkg::t_token o_tok
);

    logic [lvt_pkg::WORD_W-1:0] r_label;
    logic [lvt_pkg::WORD_W-1:0] n_label;
    logic [lvt_pkg::WORD_W-1:0] r_value;
    logic [lvt_pkg::WORD_W-1:0] n_value;
    lvt_pkg::t_token            r_tok;
    lvt_pkg::t_token            n_tok;

    // Entries fill from the low end and never empty again, so an insert that
    // reaches the first empty entry without a match has seen every label.
    always_comb begin
        n_tok   = i_tok;
        n_label = r_label;
        n_value = r_value;
        if (i_tok.valid && !i_tok.done) begin
            if (r_label == i_tok.key) begin
                n_tok.done = 1'b1;
                if (i_tok.mode == lvt_pkg::MODE_LOOKUP) begin
                    n_tok.data = r_value;
                end else begin
                    n_tok.fail = 1'b1;
                end
            end else if (i_tok.mode == lvt_pkg::MODE_INSERT &&
                         r_label == lvt_pkg::EMPTY_LABEL) begin
                n_label    = i_tok.key;
                n_value    = i_tok.value;
                n_tok.done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label   <= lvt_pkg::EMPTY_LABEL;
            r_value   <= '0;
            r_tok     <= '0;
        end else begin
            r_label   <= n_label;
            r_value   <= n_value;
            r_tok     <= n_tok;
        end
    end

    assign o_tok = r_tok;

    a_write_only_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_label != $past(r_label)) |-> ($past(r_label) == lvt_pkg::EMPTY_LABEL))
        else $error("entry overwritten while occupied");

    a_write_from_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_label != $past(r_label)) |->
            ($past(i_tok.valid) && $past(i_tok.mode) == lvt_pkg::MODE_INSERT
             && !$past(i_tok.done)))
        else $error("entry written without a pending insert");

    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tok.valid && i_tok.done) |=> (r_tok.valid && r_tok.done))
        else $error("finished request lost its done mark");

endmodule

// ===== hdl/label_value_table.sv =====
// Label/value table: ENTRIES label and value pairs, cleared to empty (label 0)
// at reset. An insert (mode 0) fills the lowest empty entry and fails on a
// duplicate label or a full table; a lookup (mode 1) returns the value of the
// matching entry, or 0xBF800000 with failed set on a miss. Each request travels
// down a row of ENTRIES cells, one entry per cell and one cell per clock, and the
// result beat is registered behind the last cell. One request is in flight at a
// time; the next is accepted in the cycle its predecessor's result beat is taken.
module label_value_table #(
    parameter int ENTRIES = lvt_pkg::ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_mode,
    input  logic signed [lvt_pkg::WORD_W-1:0] i_label,
    input  logic        [lvt_pkg::WORD_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic        [lvt_pkg::WORD_W-1:0] o_read_value,
    output logic                              o_failed
);

    lvt_pkg::t_token tok [ENTRIES+1];

    logic                       accept;
    logic                       out_take;
    logic                       r_busy;
    logic                       n_busy;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [lvt_pkg::WORD_W-1:0] r_read_value;
    logic [lvt_pkg::WORD_W-1:0] n_read_value;
    logic                       r_failed;
    logic                       n_failed;

    assign out_take = r_out_valid && i_ready;
    assign o_ready  = !r_busy || out_take;
    assign accept   = i_valid && o_ready;

    always_comb begin
        tok[0]       = '0;
        tok[0].valid = accept;
        tok[0].mode  = i_mode;
        tok[0].key   = $unsigned(i_label);
        tok[0].value = i_value;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lvt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    // Finish the beat at the end of the row: no cell claimed it means a miss
    // or a full table.
    always_comb begin
        n_busy       = r_busy;
        n_out_valid  = r_out_valid;
        n_read_value = r_read_value;
        n_failed     = r_failed;
        if (out_take) begin
            n_busy      = 1'b0;
            n_out_valid = 1'b0;
        end
        if (accept) begin
            n_busy = 1'b1;
        end
        if (tok[ENTRIES].valid) begin
            n_out_valid = 1'b1;
            if (tok[ENTRIES].done) begin
                n_read_value = tok[ENTRIES].data;
                n_failed     = tok[ENTRIES].fail;
            end else begin
                n_read_value = (tok[ENTRIES].mode == lvt_pkg::MODE_LOOKUP) ?
                               lvt_pkg::MISS_PATTERN : '0;
                n_failed     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_read_value <= n_read_value;
        r_failed     <= n_failed;
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_failed     = r_failed;

    a_out_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_busy)
        else $error("result held with no request in flight");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[ENTRIES].valid |-> (!r_out_valid || i_ready))
        else $error("result arrived while previous beat still held");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (!r_busy || out_take))
        else $error("request accepted while another is in flight");

endmodule

// ===== dv/lvt_checker.sv =====
`timescale 1ns / 100ps

module lvt_checker #(
    parameter int ENTRIES = lvt_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_ready,
    input  logic                        i_mode,
    input  logic [lvt_pkg::WORD_W-1:0]  i_label,
    input  logic [lvt_pkg::WORD_W-1:0]  i_value,
    input  logic                        i_rsp_valid,
    input  logic                        i_rsp_ready,
    input  logic [lvt_pkg::WORD_W-1:0]  i_read_value,
    input  logic                        i_failed,
    output int                          o_errors,
    output int                          o_pending
);

    typedef struct packed {
        logic [lvt_pkg::WORD_W-1:0] read_value;
        logic                       failed;
    } t_answer;

    logic [lvt_pkg::WORD_W-1:0] shadow_labels [ENTRIES];
    logic [lvt_pkg::WORD_W-1:0] shadow_values [ENTRIES];
    t_answer                    answers_due [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // Lowest entry holding this label, or ENTRIES when there is none.
    function automatic int slot_of(input logic [lvt_pkg::WORD_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_labels[i] == key) begin
                return i;
            end
        end
        return ENTRIES;
    endfunction

    // Apply one request to the shadow table and return the response it earns.
    function automatic t_answer table_response(input logic mode,
                                               input logic [lvt_pkg::WORD_W-1:0] key,
                                               input logic [lvt_pkg::WORD_W-1:0] val);
        t_answer ans;
        int      slot;
        ans.read_value = '0;
        ans.failed     = 1'b0;
        if (mode == lvt_pkg::MODE_INSERT) begin
            if (slot_of(key) < ENTRIES) begin
                // duplicate; label zero lands here while any entry is empty
                ans.failed = 1'b1;
            end else begin
                slot = slot_of(lvt_pkg::EMPTY_LABEL);
                if (slot < ENTRIES) begin
                    shadow_labels[slot] = key;
                    shadow_values[slot] = val;
                end else begin
                    ans.failed = 1'b1;
                end
            end
        end else begin
            slot = slot_of(key);
            if (slot < ENTRIES) begin
                ans.read_value = shadow_values[slot];
            end else begin
                ans.read_value = lvt_pkg::MISS_PATTERN;
                ans.failed     = 1'b1;
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_answer due;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                shadow_labels[i] = lvt_pkg::EMPTY_LABEL;
                shadow_values[i] = '0;
            end
            answers_due.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (answers_due.size() == 0) begin
                    $error("result beat with no request outstanding: read_value %h failed %b",
                           i_read_value, i_failed);
                    o_errors++;
                end else begin
                    due = answers_due.pop_front();
                    if (i_read_value !== due.read_value) begin
                        $error("read_value: expected %h, actual %h",
                               due.read_value, i_read_value);
                        o_errors++;
                    end
                    if (i_failed !== due.failed) begin
                        $error("failed: expected %b, actual %b", due.failed, i_failed);
                        o_errors++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                answers_due.push_back(table_response(i_mode, i_label, i_value));
            end
        end
        o_pending <= answers_due.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_ITEMS = 1740;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int RUN_LIMIT    = 5_000_000;

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       i_mode  = lvt_pkg::MODE_INSERT;
    logic [lvt_pkg::WORD_W-1:0] i_label = '0;
    logic [lvt_pkg::WORD_W-1:0] i_value = '0;
    logic                       i_ready = 1'b0;
    logic                       o_ready;
    logic                       o_valid;
    logic [lvt_pkg::WORD_W-1:0] o_read_value;
    logic                       o_failed;

    int                         fail_count;
    int                         results_owed;
    logic                       steady    = 1'b0;
    logic                       hold_req  = 1'b0;
    logic                       hold_done = 1'b0;
    int                         hold_left = 0;
    logic [lvt_pkg::WORD_W-1:0] sent_labels [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    label_value_table DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_label      (i_label),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_value (o_read_value),
        .o_failed     (o_failed)
    );

    lvt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_mode       (i_mode),
        .i_label      (i_label),
        .i_value      (i_value),
        .i_rsp_valid  (o_valid),
        .i_rsp_ready  (i_ready),
        .i_read_value (o_read_value),
        .i_failed     (o_failed),
        .o_errors     (fail_count),
        .o_pending    (results_owed)
    );

    // Result side: random back-pressure, one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_ready <= steady || ($urandom_range(99) >= 24);
        end
    end

    // Offer one beat and hold it until the block takes it.
    task automatic send_beat(input logic mode, input logic [lvt_pkg::WORD_W-1:0] lab,
                             input logic [lvt_pkg::WORD_W-1:0] val);
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_label <= lab;
        i_value <= val;
        if (mode == lvt_pkg::MODE_INSERT) begin
            sent_labels.push_back(lab);
        end
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_for_drain();
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
    endtask

    function automatic logic [lvt_pkg::WORD_W-1:0] pick_label();
        int r;
        r = $urandom_range(99);
        if (r < 35 && sent_labels.size() != 0) begin
            return sent_labels[$urandom_range(sent_labels.size() - 1)];
        end else if (r < 45) begin
            return lvt_pkg::EMPTY_LABEL;
        end else if (r < 55) begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [lvt_pkg::WORD_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return lvt_pkg::MISS_PATTERN;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: label zero hits the first empty entry
        send_beat(lvt_pkg::MODE_LOOKUP, lvt_pkg::EMPTY_LABEL, 32'h0);
        send_beat(lvt_pkg::MODE_INSERT, lvt_pkg::EMPTY_LABEL, 32'hFFFF_FFFF);
        send_beat(lvt_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_beat(lvt_pkg::MODE_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_beat(lvt_pkg::MODE_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
        send_beat(lvt_pkg::MODE_INSERT, 32'hFFFF_FFFF, lvt_pkg::MISS_PATTERN);
        send_beat(lvt_pkg::MODE_INSERT, 32'h8000_0000, 32'h1234_5678);
        send_beat(lvt_pkg::MODE_LOOKUP, 32'h8000_0000, 32'h0);
        send_beat(lvt_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0);
        send_beat(lvt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_beat(lvt_pkg::MODE_LOOKUP, 32'h0000_0001, 32'h0);
        send_beat(lvt_pkg::MODE_LOOKUP, lvt_pkg::EMPTY_LABEL, 32'h0);

        // random traffic fills the table, then keeps hitting the full cases
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady <= (n >= 1000 && n < 1300);
            if (n == 400) begin
                hold_req <= 1'b1;
            end
            if (n == 700) begin
                i_valid <= 1'b0;
                wait_for_drain();
            end
            if (!(n >= 1000 && n < 1300) && $urandom_range(99) < 24) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
            send_beat(($urandom_range(99) < 40) ? lvt_pkg::MODE_INSERT : lvt_pkg::MODE_LOOKUP,
                      pick_label(), pick_value());
        end
        i_valid <= 1'b0;

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
